// ===== design/itoa_pkg.sv =====
// itoa_pkg: shared constants, codes and types of the integer to ascii formatter
// depends on nothing; used by itoa_if.sv, itoa_digits.sv and the top level
package itoa_pkg;

    // field limits
    localparam int MAX_FIELD_WIDTH = 63;
    localparam int CNT_W           = $clog2(MAX_FIELD_WIDTH + 1);
    localparam int VAL_W           = 32;
    localparam int ND_W            = 6;           // digit count, up to 32
    localparam int BCD_DIGITS      = 10;
    localparam int DIG_W           = 4 * BCD_DIGITS;
    localparam int DABBLE_STEPS    = VAL_W;
    localparam int CNT_STEP_W      = $clog2(DABBLE_STEPS + 1);

    // conversion commands
    localparam logic [3:0] CMD_HEX_UP  = 4'd0;
    localparam logic [3:0] CMD_HEX_LO  = 4'd1;
    localparam logic [3:0] CMD_BIN     = 4'd2;
    localparam logic [3:0] CMD_PTR_UP  = 4'd3;
    localparam logic [3:0] CMD_PTR_LO  = 4'd4;
    localparam logic [3:0] CMD_REG     = 4'd5;
    localparam logic [3:0] CMD_SDEC    = 4'd6;
    localparam logic [3:0] CMD_UDEC    = 4'd7;
    localparam logic [3:0] CMD_CHAR    = 4'd8;

    // digit radix codes
    localparam logic [1:0] BASE_BIN = 2'd0;
    localparam logic [1:0] BASE_HEX = 2'd1;
    localparam logic [1:0] BASE_DEC = 2'd2;

    // fixed widths of pointer and register forms
    localparam logic [CNT_W-1:0] PTR_WIDTH = CNT_W'(10);
    localparam logic [CNT_W-1:0] REG_WIDTH = CNT_W'(34);

    // ascii codes
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CASE_BIT = 8'h20;

    // request from the sequencer to the digit unit
    typedef struct packed {
        logic             start;
        logic             pop;
        logic [1:0]       base;
        logic [VAL_W-1:0] mag;
    } t_dig_req;

    // status from the digit unit
    typedef struct packed {
        logic            done;
        logic [ND_W-1:0] nd;
        logic [3:0]      digit;
    } t_dig_stat;

    // digit value to upper-case ascii
    function automatic logic [7:0] hex_char(input logic [3:0] d);
        logic [7:0] c;
        case (d)
            4'd0:    c = 8'h30;
            4'd1:    c = 8'h31;
            4'd2:    c = 8'h32;
            4'd3:    c = 8'h33;
            4'd4:    c = 8'h34;
            4'd5:    c = 8'h35;
            4'd6:    c = 8'h36;
            4'd7:    c = 8'h37;
            4'd8:    c = 8'h38;
            4'd9:    c = 8'h39;
            4'd10:   c = 8'h41;
            4'd11:   c = 8'h42;
            4'd12:   c = 8'h43;
            4'd13:   c = 8'h44;
            4'd14:   c = 8'h45;
            default: c = 8'h46;
        endcase
        return c;
    endfunction

endpackage

// ===== design/itoa_if.sv =====
// itoa_if: valid/ready channel interfaces for input items and output characters
// depends on itoa_pkg
interface itoa_in_if import itoa_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [3:0]       command;
    logic [VAL_W-1:0] value;
    logic             left_justify;
    logic             force_plus;
    logic             space_sign;
    logic             zero_pad;
    logic             has_width;
    logic [5:0]       field_width;

    modport source (
        output valid, command, value, left_justify, force_plus, space_sign,
               zero_pad, has_width, field_width,
        input  ready
    );
    modport sink (
        input  valid, command, value, left_justify, force_plus, space_sign,
               zero_pad, has_width, field_width,
        output ready
    );
endinterface

interface itoa_out_if ();
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last;

    modport source (output valid, character, last, input ready);
    modport sink   (input valid, character, last, output ready);
endinterface

// ===== design/integer_to_ascii_formatter.sv =====
// integer_to_ascii_formatter: printf-style integer conversion with padding
// depends on itoa_pkg, itoa_if (channels) and itoa_digits (digit unit)
//
//   channel  | dir | payload                                        | handshake
//   ---------+-----+------------------------------------------------+------------
//   i_in     | in  | command value flags has_width field_width      | valid/ready
//   o_out    | out | character last                                 | valid/ready
//
// one item at a time; i_in.ready is high only while the sequencer is idle
// per item: a load, 32 shift-add steps for decimal, up to 31 (binary), 7 (hex)
//   or 9 (decimal) leading zero strip steps, a leading digit check, a hand-over,
//   then one character per cycle through the output register while o_out is ready
// a character command skips the digit unit; undefined commands are dropped
// reset is synchronous active low; o_out stalls hold the sequencer in place
module integer_to_ascii_formatter import itoa_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    itoa_in_if.sink    i_in,
    itoa_out_if.source o_out
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CONV = 4'd1;
    localparam logic [3:0] S_SIGN = 4'd2;
    localparam logic [3:0] S_PFX0 = 4'd3;
    localparam logic [3:0] S_PFX1 = 4'd4;
    localparam logic [3:0] S_PADL = 4'd5;
    localparam logic [3:0] S_DIG  = 4'd6;
    localparam logic [3:0] S_PADR = 4'd7;
    localparam logic [3:0] S_CHAR = 4'd8;

    logic [3:0]       r_state, n_state;
    logic [7:0]       r_sign, n_sign;
    logic             r_pfx, n_pfx;
    logic [7:0]       r_pfx_ch, n_pfx_ch;
    logic [7:0]       r_lower, n_lower;
    logic             r_left, n_left;
    logic             r_zpad, n_zpad;
    logic [CNT_W-1:0] r_width, n_width;
    logic [CNT_W-1:0] r_pad, n_pad;
    logic [7:0]       r_char, n_char;
    logic             r_ovalid, n_ovalid;
    logic [7:0]       r_ochar, n_ochar;
    logic             r_olast, n_olast;

    t_dig_req   dig_req;
    t_dig_stat  dig_stat;
    logic       adv;
    logic       emit;
    logic [7:0] e_char;
    logic [3:0] e_next;
    logic [3:0] after_sign, after_pfx, after_dig;
    logic [CNT_W-1:0] used;
    logic [CNT_W-1:0] pad_calc;
    logic [CNT_W-1:0] req_width;
    logic [VAL_W-1:0] mag;

    itoa_digits u_digits (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (dig_req),
        .o_stat  (dig_stat)
    );

    // output slot can take a character
    assign adv = !r_ovalid || o_out.ready;

    // requested width, clamped
    always_comb begin
        if (!i_in.has_width) begin
            req_width = '0;
        end else if (CNT_W'(i_in.field_width) > CNT_W'(MAX_FIELD_WIDTH)) begin
            req_width = CNT_W'(MAX_FIELD_WIDTH);
        end else begin
            req_width = CNT_W'(i_in.field_width);
        end
    end

    // magnitude for the digit unit
    always_comb begin
        if (i_in.command == CMD_SDEC && i_in.value[VAL_W-1]) begin
            mag = VAL_W'(0) - i_in.value;
        end else begin
            mag = i_in.value;
        end
    end

    // padding from the final digit count
    always_comb begin
        used = CNT_W'(dig_stat.nd) + (r_pfx ? CNT_W'(2) : CNT_W'(0))
             + ((r_sign != 8'h00) ? CNT_W'(1) : CNT_W'(0));
        pad_calc = (r_width > used) ? (r_width - used) : CNT_W'(0);
    end

    // order of the output sections
    always_comb begin
        after_pfx  = (!r_left && r_pad != '0) ? S_PADL : S_DIG;
        after_sign = r_pfx ? S_PFX0 : after_pfx;
        after_dig  = (r_left && r_pad != '0) ? S_PADR : S_IDLE;
    end

    // character and follow-on state of the current section
    always_comb begin
        emit   = 1'b1;
        e_char = 8'h00;
        e_next = r_state;
        case (r_state)
            S_SIGN: begin
                e_char = r_sign;
                e_next = after_sign;
            end
            S_PFX0: begin
                e_char = CH_ZERO;
                e_next = S_PFX1;
            end
            S_PFX1: begin
                e_char = r_pfx_ch;
                e_next = after_pfx;
            end
            S_PADL: begin
                e_char = r_zpad ? CH_ZERO : CH_SPACE;
                e_next = (r_pad == CNT_W'(1)) ? S_DIG : S_PADL;
            end
            S_DIG: begin
                e_char = hex_char(dig_stat.digit) | r_lower;
                e_next = (dig_stat.nd == ND_W'(1)) ? after_dig : S_DIG;
            end
            S_PADR: begin
                e_char = r_zpad ? CH_ZERO : CH_SPACE;
                e_next = (r_pad == CNT_W'(1)) ? S_IDLE : S_PADR;
            end
            S_CHAR: begin
                e_char = r_char;
                e_next = S_IDLE;
            end
            default: emit = 1'b0;
        endcase
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_sign   = r_sign;
        n_pfx    = r_pfx;
        n_pfx_ch = r_pfx_ch;
        n_lower  = r_lower;
        n_left   = r_left;
        n_zpad   = r_zpad;
        n_width  = r_width;
        n_pad    = r_pad;
        n_char   = r_char;
        n_ovalid = r_ovalid && !o_out.ready;
        n_ochar  = r_ochar;
        n_olast  = r_olast;
        dig_req.start = 1'b0;
        dig_req.pop   = 1'b0;
        dig_req.base  = BASE_DEC;
        dig_req.mag   = mag;

        case (i_in.command)
            CMD_BIN, CMD_REG: dig_req.base = BASE_BIN;
            CMD_HEX_UP, CMD_HEX_LO, CMD_PTR_UP, CMD_PTR_LO: dig_req.base = BASE_HEX;
            default: dig_req.base = BASE_DEC;
        endcase

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_sign   = 8'h00;
                    n_pfx    = 1'b0;
                    n_pfx_ch = CH_X;
                    n_lower  = 8'h00;
                    n_left   = i_in.left_justify;
                    n_zpad   = i_in.zero_pad;
                    n_width  = req_width;
                    n_char   = i_in.value[7:0];
                    n_state  = S_CONV;
                    dig_req.start = 1'b1;
                    case (i_in.command)
                        CMD_HEX_UP: n_pfx = 1'b1;
                        CMD_HEX_LO: begin
                            n_pfx   = 1'b1;
                            n_lower = CASE_BIT;
                        end
                        CMD_BIN: begin
                            n_pfx    = 1'b1;
                            n_pfx_ch = CH_B;
                        end
                        CMD_PTR_UP, CMD_PTR_LO: begin
                            n_pfx   = 1'b1;
                            n_width = PTR_WIDTH;
                            n_zpad  = 1'b1;
                            n_lower = (i_in.command == CMD_PTR_LO) ? CASE_BIT : 8'h00;
                        end
                        CMD_REG: begin
                            n_pfx    = 1'b1;
                            n_pfx_ch = CH_B;
                            n_width  = REG_WIDTH;
                            n_zpad   = 1'b1;
                        end
                        CMD_SDEC: begin
                            if (i_in.value[VAL_W-1]) begin
                                n_sign = CH_MINUS;
                            end else if (i_in.force_plus) begin
                                n_sign = CH_PLUS;
                            end else if (i_in.space_sign) begin
                                n_sign = CH_SPACE;
                            end
                        end
                        CMD_UDEC: n_sign = 8'h00;
                        CMD_CHAR: begin
                            dig_req.start = 1'b0;
                            n_state       = S_CHAR;
                        end
                        default: begin
                            dig_req.start = 1'b0;
                            n_state       = S_IDLE;
                        end
                    endcase
                end
            end
            S_CONV: begin
                if (dig_stat.done) begin
                    n_pad = pad_calc;
                    if (r_sign != 8'h00) begin
                        n_state = S_SIGN;
                    end else if (r_pfx) begin
                        n_state = S_PFX0;
                    end else if (!r_left && pad_calc != '0) begin
                        n_state = S_PADL;
                    end else begin
                        n_state = S_DIG;
                    end
                end
            end
            default: begin
                // one character into the output register
                if (emit && adv) begin
                    n_ovalid = 1'b1;
                    n_ochar  = e_char;
                    n_olast  = (e_next == S_IDLE);
                    n_state  = e_next;
                    if (r_state == S_DIG) begin
                        dig_req.pop = 1'b1;
                    end
                    if (r_state == S_PADL || r_state == S_PADR) begin
                        n_pad = r_pad - CNT_W'(1);
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
        r_sign   <= n_sign;
        r_pfx    <= n_pfx;
        r_pfx_ch <= n_pfx_ch;
        r_lower  <= n_lower;
        r_left   <= n_left;
        r_zpad   <= n_zpad;
        r_width  <= n_width;
        r_pad    <= n_pad;
        r_char   <= n_char;
        r_ochar  <= n_ochar;
        r_olast  <= n_olast;
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_ovalid;
    assign o_out.character = r_ochar;
    assign o_out.last      = r_olast;

endmodule

// ===== design/itoa_digits.sv =====
// itoa_digits: shared shift unit that forms the digits of a magnitude
// binary to bcd by shift-and-add-3 for decimal, leading zero strip, then digit pop
// depends on itoa_pkg
module itoa_digits import itoa_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dig_req  i_req,
    output t_dig_stat o_stat
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DABBLE = 2'd1;
    localparam logic [1:0] ST_NORM   = 2'd2;
    localparam logic [1:0] ST_HOLD   = 2'd3;

    logic [1:0]            r_state, n_state;
    logic [1:0]            r_base, n_base;
    logic [DIG_W-1:0]      r_dig, n_dig;
    logic [VAL_W-1:0]      r_bin, n_bin;
    logic [ND_W-1:0]       r_nd, n_nd;
    logic [CNT_STEP_W-1:0] r_cnt, n_cnt;
    logic [3:0]            top_digit;
    logic [DIG_W-1:0]      dig_shift;
    logic [DIG_W-1:0]      bcd_adj;

    // most significant digit for the current radix
    always_comb begin
        case (r_base)
            BASE_BIN: top_digit = {3'b000, r_dig[VAL_W-1]};
            BASE_HEX: top_digit = r_dig[VAL_W-1 -: 4];
            default:  top_digit = r_dig[DIG_W-1 -: 4];
        endcase
    end

    // one digit left
    always_comb begin
        if (r_base == BASE_BIN) begin
            dig_shift = {r_dig[DIG_W-2:0], 1'b0};
        end else begin
            dig_shift = {r_dig[DIG_W-5:0], 4'b0000};
        end
    end

    // add 3 to each bcd digit of 5 or more
    always_comb begin
        for (int k = 0; k < BCD_DIGITS; k++) begin
            if (r_dig[4*k +: 4] >= 4'd5) begin
                bcd_adj[4*k +: 4] = r_dig[4*k +: 4] + 4'd3;
            end else begin
                bcd_adj[4*k +: 4] = r_dig[4*k +: 4];
            end
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_base  = r_base;
        n_dig   = r_dig;
        n_bin   = r_bin;
        n_nd    = r_nd;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                if (i_req.start) begin
                    n_base = i_req.base;
                    if (i_req.base == BASE_DEC) begin
                        n_dig   = '0;
                        n_bin   = i_req.mag;
                        n_cnt   = CNT_STEP_W'(DABBLE_STEPS);
                        n_state = ST_DABBLE;
                    end else begin
                        n_dig   = {(DIG_W-VAL_W)'(0), i_req.mag};
                        n_nd    = (i_req.base == BASE_BIN) ? ND_W'(VAL_W) : ND_W'(VAL_W / 4);
                        n_state = ST_NORM;
                    end
                end
            end
            ST_DABBLE: begin
                n_dig = {bcd_adj[DIG_W-2:0], r_bin[VAL_W-1]};
                n_bin = {r_bin[VAL_W-2:0], 1'b0};
                n_cnt = r_cnt - CNT_STEP_W'(1);
                if (r_cnt == CNT_STEP_W'(1)) begin
                    n_nd    = ND_W'(BCD_DIGITS);
                    n_state = ST_NORM;
                end
            end
            ST_NORM: begin
                if (top_digit == 4'd0 && r_nd > ND_W'(1)) begin
                    n_dig = dig_shift;
                    n_nd  = r_nd - ND_W'(1);
                end else begin
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (i_req.pop) begin
                    n_dig = dig_shift;
                    n_nd  = r_nd - ND_W'(1);
                    if (r_nd == ND_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_base <= n_base;
        r_dig  <= n_dig;
        r_bin  <= n_bin;
        r_nd   <= n_nd;
        r_cnt  <= n_cnt;
    end

    assign o_stat.done  = (r_state == ST_HOLD);
    assign o_stat.nd    = r_nd;
    assign o_stat.digit = top_digit;

endmodule
